// ===== sv/rfdo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdo_pkg
// Types and constants shared by the drop-oldest record FIFO.
// ----------------------------------------------------------------------------
package rfdo_pkg;

  localparam int unsigned CfgW = 5;
  localparam int unsigned LenW = 7;

  localparam logic [CfgW-1:0] CFG_LIMIT_RST = 5'd16;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FAIL  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] timestamp;
    logic [3:0]  peek_offset;
  } item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [31:0]     sequence_res;
    logic [31:0]     record_time;
    logic [7:0]      out_byte;
    logic [LenW-1:0] record_length;
    logic            last_result;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_STREAM
  } state_e;

endpackage

// ===== sv/record_fifo_drop_oldest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_fifo_drop_oldest
// Bounded ring FIFO of byte records that drops the oldest record when the configured limit is reached.
// ----------------------------------------------------------------------------
// Push bytes are taken one per cycle with busy low; the last byte of a record
// gives one result on the next cycle. A pop or peek holds busy while the
// record header is read from the slot memory, together with the first payload
// byte, and then while it streams one byte result per cycle from the payload
// memory, whose read is registered; a record of zero bytes gives one result
// with a zero byte. A failing pop or peek gives one result on the next cycle.
// The receiver cannot stall: every result is valid for exactly one cycle under
// res_valid_o.
module record_fifo_drop_oldest
  import rfdo_pkg::*;
#(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  item_t           item_i,
  output logic            res_valid_o,
  output result_t         res_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned SlotW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned SumW     = (CntW + 1 > 5) ? CntW + 1 : 5;
  localparam int unsigned PosW     = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned PayDepth = CAPACITY * MAX_PAYLOAD;
  localparam int unsigned AddrW    = (PayDepth > 1) ? $clog2(PayDepth) : 1;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [31:0]     seq;
    logic [31:0]     stamp;
  } meta_t;

  logic [7:0] pay_mem  [PayDepth];
  meta_t      meta_mem [CAPACITY];

  state_e            state_q, state_d;
  logic [SlotW-1:0]  oldest_q, oldest_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [31:0]       next_seq_q, next_seq_d;
  logic [PosW-1:0]   fill_pos_q, fill_pos_d;
  logic              filling_q, filling_d;
  logic              trunc_q, trunc_d;
  logic [CfgW-1:0]   limit_q;
  logic [PosW-1:0]   rd_pos_q, rd_pos_d;
  logic              is_pop_q, is_pop_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  logic [SlotW-1:0]  fill_slot_q, fill_slot_d;
  logic [31:0]       fill_seq_q, fill_seq_d;
  logic [31:0]       fill_time_q, fill_time_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [7:0]        pay_rdata_q;
  meta_t             meta_rdata_q;

  logic              accept, is_push, is_pop, is_peek;
  logic              meta_re, pay_re;
  logic [CntW-1:0]   lim, cnt_b, drop, cnt_cur;
  logic              evict, commit, pay_we, op_ok, stream_last;
  logic [SumW-1:0]   sum_evict, sum_fill, sum_peek, sum_next;
  logic [SlotW-1:0]  oldest_b, fill_slot_b, slot_cur, peek_slot, slot_next;
  logic [PosW-1:0]   pos_cur, pos_new;
  logic              trunc_cur, trunc_new;
  logic [31:0]       seq_cur, time_cur;
  logic [AddrW-1:0]  pay_waddr, pay_raddr;

  function automatic logic [SlotW-1:0] ring_wrap(input logic [SumW-1:0] s);
    logic [SumW-1:0] r;
    r = s;
    if (s >= SumW'(CAPACITY)) begin
      r = s - SumW'(CAPACITY);
    end
    return SlotW'(r);
  endfunction

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if ((is_pop || is_peek) && op_ok) begin
          state_d = ST_META;
        end
      end
      ST_META: begin
        state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (stream_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // FSM outputs
  always_comb begin
    busy    = 1'b1;
    meta_re = 1'b0;
    pay_re  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_META: begin
        meta_re = 1'b1;
        pay_re  = 1'b1;
      end
      ST_STREAM: begin
        pay_re = !stream_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign accept  = start && !busy;
  assign is_push = accept && (item_i.op == OP_PUSH);
  assign is_pop  = accept && (item_i.op == OP_POP);
  assign is_peek = accept && (item_i.op == OP_PEEK);

  assign stream_last = (LenW'(rd_pos_q) >= meta_rdata_q.len);

  always_comb begin
    if (limit_q == '0) begin
      lim = CntW'(1);
    end else if (32'(limit_q) > CAPACITY) begin
      lim = CntW'(CAPACITY);
    end else begin
      lim = CntW'(limit_q);
    end
  end

  // push bookkeeping
  assign evict       = (count_q >= lim);
  assign drop        = count_q - lim + CntW'(1);
  assign sum_evict   = SumW'(oldest_q) + SumW'(drop);
  assign oldest_b    = evict ? ring_wrap(sum_evict) : oldest_q;
  assign cnt_b       = evict ? lim - CntW'(1) : count_q;
  assign sum_fill    = SumW'(oldest_b) + SumW'(cnt_b);
  assign fill_slot_b = ring_wrap(sum_fill);

  assign slot_cur  = filling_q ? fill_slot_q : fill_slot_b;
  assign pos_cur   = filling_q ? fill_pos_q : '0;
  assign trunc_cur = filling_q && trunc_q;
  assign seq_cur   = filling_q ? fill_seq_q : next_seq_q;
  assign time_cur  = filling_q ? fill_time_q : item_i.timestamp;
  assign cnt_cur   = filling_q ? count_q : cnt_b;
  assign pay_we    = is_push && (32'(pos_cur) < MAX_PAYLOAD);
  assign pos_new   = pay_we ? pos_cur + PosW'(1) : pos_cur;
  assign trunc_new = trunc_cur || !pay_we;
  assign commit    = is_push && item_i.last_byte;

  assign sum_peek  = SumW'(oldest_q) + SumW'(item_i.peek_offset);
  assign peek_slot = ring_wrap(sum_peek);
  assign sum_next  = SumW'(slot_q) + SumW'(1);
  assign slot_next = ring_wrap(sum_next);

  always_comb begin
    op_ok = 1'b0;
    if (item_i.op == OP_POP) begin
      op_ok = (count_q != '0);
    end else if (item_i.op == OP_PEEK) begin
      op_ok = (SumW'(item_i.peek_offset) < SumW'(count_q));
    end
  end

  assign pay_waddr = AddrW'(slot_cur) * AddrW'(MAX_PAYLOAD) + AddrW'(pos_cur);
  assign pay_raddr = AddrW'(slot_q) * AddrW'(MAX_PAYLOAD) + AddrW'(rd_pos_q);

  // datapath next values
  always_comb begin
    oldest_d    = oldest_q;
    count_d     = count_q;
    next_seq_d  = next_seq_q;
    fill_pos_d  = fill_pos_q;
    filling_d   = filling_q;
    trunc_d     = trunc_q;
    rd_pos_d    = rd_pos_q;
    is_pop_d    = is_pop_q;
    fill_slot_d = fill_slot_q;
    fill_seq_d  = fill_seq_q;
    fill_time_d = fill_time_q;
    slot_d      = slot_q;
    res_valid_d = 1'b0;
    res_d       = '0;

    if (is_push) begin
      if (!filling_q) begin
        oldest_d    = oldest_b;
        count_d     = cnt_b;
        next_seq_d  = next_seq_q + 32'd1;
        fill_slot_d = fill_slot_b;
        fill_seq_d  = next_seq_q;
        fill_time_d = item_i.timestamp;
      end
      fill_pos_d = pos_new;
      trunc_d    = trunc_new;
      filling_d  = 1'b1;
      if (commit) begin
        count_d                   = cnt_cur + CntW'(1);
        filling_d                 = 1'b0;
        fill_pos_d                = '0;
        trunc_d                   = 1'b0;
        res_valid_d               = 1'b1;
        res_d.status              = trunc_new ? STAT_TRUNC : STAT_OK;
        res_d.sequence_res        = seq_cur;
        res_d.record_time         = time_cur;
        res_d.record_length       = LenW'(pos_new);
        res_d.last_result         = 1'b1;
      end
    end

    if (is_pop || is_peek) begin
      if (op_ok) begin
        slot_d   = is_pop ? oldest_q : peek_slot;
        is_pop_d = is_pop;
        rd_pos_d = '0;
      end else begin
        res_valid_d       = 1'b1;
        res_d.status      = STAT_FAIL;
        res_d.last_result = 1'b1;
      end
    end

    if (pay_re) begin
      rd_pos_d = rd_pos_q + PosW'(1);
    end

    if (state_q == ST_STREAM) begin
      res_valid_d         = 1'b1;
      res_d.status        = STAT_OK;
      res_d.sequence_res  = meta_rdata_q.seq;
      res_d.record_time   = meta_rdata_q.stamp;
      res_d.out_byte      = (meta_rdata_q.len == '0) ? 8'd0 : pay_rdata_q;
      res_d.record_length = meta_rdata_q.len;
      res_d.last_result   = stream_last;
      if (stream_last && is_pop_q) begin
        oldest_d = slot_next;
        count_d  = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      next_seq_q  <= '0;
      fill_pos_q  <= '0;
      filling_q   <= 1'b0;
      trunc_q     <= 1'b0;
      limit_q     <= CFG_LIMIT_RST;
      rd_pos_q    <= '0;
      is_pop_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      next_seq_q  <= next_seq_d;
      fill_pos_q  <= fill_pos_d;
      filling_q   <= filling_d;
      trunc_q     <= trunc_d;
      rd_pos_q    <= rd_pos_d;
      is_pop_q    <= is_pop_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_slot_q <= fill_slot_d;
    fill_seq_q  <= fill_seq_d;
    fill_time_q <= fill_time_d;
    slot_q      <= slot_d;
    res_q       <= res_d;
  end

  // payload memory
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= item_i.payload_byte;
    end
    if (pay_re) begin
      pay_rdata_q <= pay_mem[pay_raddr];
    end
  end

  // record header memory
  always_ff @(posedge clk_i) begin
    if (commit) begin
      meta_mem[slot_cur] <= '{len: LenW'(pos_new), seq: seq_cur, stamp: time_cur};
    end
    if (meta_re) begin
      meta_rdata_q <= meta_mem[slot_q];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("record count above capacity");

  a_stream_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STREAM |=> res_valid_o)
    else $error("gap in streamed record");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.last_result)
    else $error("busy dropped without final result");

  a_no_push_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_META |=> res_valid_o == 1'b0)
    else $error("result during header read");

endmodule
